// File: hdl/sfbd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sfbd_pkg
// constants and register codes of the spectral flux beat detector
// ----------------------------------------------------------------------------
package sfbd_pkg;

    localparam int MAX_BINS = 1024;
    localparam int MAG_BITS = 24;

    // port widths fixed by the interface
    localparam int MAG_W   = 24;
    localparam int BAND_W  = 10;
    localparam int THR_W   = 24;
    localparam int FLUX_W  = 35;
    localparam int CFG_A_W = 2;
    localparam int CFG_D_W = 24;

    // derived widths
    localparam int BIN_W = $clog2(MAX_BINS);
    localparam int CNT_W = $clog2(MAX_BINS + 1);
    localparam int CMP_W = 16;
    localparam int SUM_W = MAG_BITS + CNT_W + 1;

    localparam logic [CNT_W-1:0] CNT_LIMIT = CNT_W'(MAX_BINS);

    // register indexes
    localparam logic [CFG_A_W-1:0] CFG_BAND_LOW  = 2'd0;
    localparam logic [CFG_A_W-1:0] CFG_BAND_HIGH = 2'd1;
    localparam logic [CFG_A_W-1:0] CFG_THRESHOLD = 2'd2;

    localparam logic [BAND_W-1:0] BAND_LOW_RST  = 10'd0;
    localparam logic [BAND_W-1:0] BAND_HIGH_RST = 10'd11;
    localparam logic [THR_W-1:0]  THRESHOLD_RST = 24'd5898;

    typedef logic signed [SUM_W-1:0]  t_sum;
    typedef logic signed [FLUX_W-1:0] t_flux;

    localparam t_flux FLUX_MAX = {1'b0, {(FLUX_W-1){1'b1}}};
    localparam t_flux FLUX_MIN = {1'b1, {(FLUX_W-1){1'b0}}};

endpackage
`default_nettype wire

// File: hdl/spectral_flux_beat_detector.sv
`default_nettype none
// ----------------------------------------------------------------------------
// spectral_flux_beat_detector
// streams spectrum bins, diffs each against the previous frame held in a
// block ram, sums the flux over all bins and over a band, flags beats
// ----------------------------------------------------------------------------
//  channel  | handshake                   | payload
//  ---------+-----------------------------+----------------------------------
//  bin in   | i_in_valid / o_in_ready     | i_magnitude, i_frame_end
//  beat out | o_out_valid / i_out_ready   | o_band_flux, o_total_flux,
//           |                             | o_over_threshold, o_beat
//  config   | i_cfg_we                    | i_cfg_idx, i_cfg_data
//
//  one bin per cycle unless the pipeline stalls; a beat follows its frame's
//  last bin through the ram read, sum and threshold stages. the previous-frame
//  ram has one read and one write port; a read of the entry being written is
//  forwarded.
//  reset clears control and sums; ram contents stay undefined until written.
//  the pipeline stalls only while a finished beat waits and the output
//  register is still full.
// ----------------------------------------------------------------------------
module spectral_flux_beat_detector
    import sfbd_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_we,
    input  wire logic [CFG_A_W-1:0]   i_cfg_idx,
    input  wire logic [CFG_D_W-1:0]   i_cfg_data,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire logic [MAG_W-1:0]     i_magnitude,
    input  wire logic                 i_frame_end,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output logic signed [FLUX_W-1:0]  o_band_flux,
    output logic signed [FLUX_W-1:0]  o_total_flux,
    output logic                      o_over_threshold,
    output logic                      o_beat
);

    // configuration
    logic [BAND_W-1:0] r_band_low;
    logic [BAND_W-1:0] r_band_high;
    logic [THR_W-1:0]  r_threshold;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_low  <= BAND_LOW_RST;
            r_band_high <= BAND_HIGH_RST;
            r_threshold <= THRESHOLD_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_BAND_LOW:  r_band_low  <= i_cfg_data[BAND_W-1:0];
                CFG_BAND_HIGH: r_band_high <= i_cfg_data[BAND_W-1:0];
                CFG_THRESHOLD: r_threshold <= i_cfg_data[THR_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // previous frame memory
    logic [MAG_BITS-1:0] r_mem [MAX_BINS];
    logic [MAG_BITS-1:0] r_rd_data;

    // pipeline registers
    logic                r_bin_cnt_vld;
    logic [CNT_W-1:0]    r_bin_cnt;
    logic                r1_valid;
    logic [MAG_BITS-1:0] r1_mag;
    logic [BIN_W-1:0]    r1_idx;
    logic                r1_inr;
    logic                r1_band;
    logic                r1_last;
    logic                r1_fwd;
    logic [MAG_BITS-1:0] r1_fwd_mag;

    t_sum r_band_sum;
    t_sum r_all_sum;
    logic r_have_prev;

    logic r2_valid;
    t_sum r2_band;
    t_sum r2_all;
    logic r2_have;

    logic r_prev_beat;
    logic r_out_valid;

    // flow control
    logic out_free;
    logic adv;
    logic in_acc;

    assign out_free   = !r_out_valid || i_out_ready;
    assign adv        = !r2_valid || out_free;
    assign o_in_ready = adv;
    assign in_acc     = i_in_valid && adv;

    // stage 0: address and band decode
    logic [BIN_W-1:0]    s0_idx;
    logic                s0_inr;
    logic [CMP_W-1:0]    s0_idx_c;
    logic [CMP_W-1:0]    s0_lo_c;
    logic [CMP_W-1:0]    s0_hi_c;
    logic                s0_band;
    logic                s0_fwd;
    logic [CNT_W-1:0]    n_bin_cnt;

    assign s0_idx   = r_bin_cnt[BIN_W-1:0];
    assign s0_inr   = r_bin_cnt < CNT_LIMIT;
    assign s0_idx_c = CMP_W'(s0_idx);
    assign s0_hi_c  = CMP_W'(r_band_high);
    // low bound clamped to high bound
    assign s0_lo_c  = (r_band_low > r_band_high) ? CMP_W'(r_band_high) : CMP_W'(r_band_low);
    assign s0_band  = (s0_idx_c >= s0_lo_c) && (s0_idx_c <= s0_hi_c);
    // stage 1 writes the entry we read this edge
    assign s0_fwd   = r1_valid && r1_inr && (r1_idx == s0_idx);

    always_comb begin
        n_bin_cnt = r_bin_cnt;
        if (i_frame_end) begin
            n_bin_cnt = '0;
        end else if (s0_inr) begin
            n_bin_cnt = r_bin_cnt + CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc && s0_inr) begin
            r_rd_data <= r_mem[s0_idx];
        end
        if (adv && r1_valid && r1_inr) begin
            r_mem[r1_idx] <= r1_mag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bin_cnt     <= '0;
            r_bin_cnt_vld <= 1'b0;
            r1_valid      <= 1'b0;
        end else if (adv) begin
            r1_valid      <= i_in_valid;
            r_bin_cnt_vld <= 1'b1;
            if (i_in_valid) begin
                r_bin_cnt <= n_bin_cnt;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r1_mag     <= i_magnitude[MAG_BITS-1:0];
            r1_idx     <= s0_idx;
            r1_inr     <= s0_inr;
            r1_band    <= s0_band;
            r1_last    <= i_frame_end;
            r1_fwd     <= s0_fwd;
            r1_fwd_mag <= r1_mag;
        end
    end

    // stage 1: difference and accumulate
    logic [MAG_BITS-1:0] s1_prev;
    t_sum                s1_diff;
    t_sum                n_band_sum;
    t_sum                n_all_sum;

    assign s1_prev = r1_fwd ? r1_fwd_mag : r_rd_data;
    assign s1_diff = t_sum'({1'b0, r1_mag}) - t_sum'({1'b0, s1_prev});

    always_comb begin
        n_band_sum = r_band_sum;
        n_all_sum  = r_all_sum;
        if (r1_inr) begin
            n_all_sum = r_all_sum + s1_diff;
            if (r1_band) begin
                n_band_sum = r_band_sum + s1_diff;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_band_sum  <= '0;
            r_all_sum   <= '0;
            r_have_prev <= 1'b0;
            r2_valid    <= 1'b0;
        end else if (adv) begin
            r2_valid <= r1_valid && r1_last;
            if (r1_valid) begin
                if (r1_last) begin
                    r_band_sum  <= '0;
                    r_all_sum   <= '0;
                    r_have_prev <= 1'b1;
                end else begin
                    r_band_sum <= n_band_sum;
                    r_all_sum  <= n_all_sum;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r1_valid && r1_last) begin
            r2_band <= n_band_sum;
            r2_all  <= n_all_sum;
            r2_have <= r_have_prev;
        end
    end

    // stage 2: saturate, threshold, edge detect
    t_flux s2_band;
    t_flux s2_all;
    logic  s2_over;

    function automatic t_flux sat_flux(input t_sum v);
        t_flux res;
        if (v > t_sum'(FLUX_MAX)) begin
            res = FLUX_MAX;
        end else if (v < t_sum'(FLUX_MIN)) begin
            res = FLUX_MIN;
        end else begin
            res = v[FLUX_W-1:0];
        end
        return res;
    endfunction

    assign s2_band = r2_have ? sat_flux(r2_band) : '0;
    assign s2_all  = r2_have ? sat_flux(r2_all) : '0;
    assign s2_over = r2_have && (s2_band > t_flux'({1'b0, r_threshold}));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_prev_beat <= 1'b0;
        end else if (r2_valid && out_free) begin
            r_out_valid <= 1'b1;
            r_prev_beat <= s2_over;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r2_valid && out_free) begin
            o_band_flux      <= s2_band;
            o_total_flux     <= s2_all;
            o_over_threshold <= s2_over;
            o_beat           <= s2_over && !r_prev_beat;
        end
    end

    assign o_out_valid = r_out_valid && r_bin_cnt_vld;

endmodule
`default_nettype wire

// File: tb/sv/tb_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the spectral flux beat detector: streams spectrum
// bins through the valid/ready input, mirrors the frame store and both flux
// sums in a local predictor, and compares every frame result that comes out
// ----------------------------------------------------------------------------
module tb_top;
    import sfbd_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int MAX_REPORTS   = 200;
    localparam int N_ROWS        = 25;

    // index 3 decodes to no register
    localparam logic [CFG_A_W-1:0] CFG_UNUSED = 2'd3;

    typedef struct packed {
        t_flux band_flux;
        t_flux total_flux;
        logic  over;
        logic  beat;
    } t_frame_result;

    typedef enum logic { ROW_BIN, ROW_CFG } t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [CFG_A_W-1:0] idx;
        logic [CFG_D_W-1:0] val;
        logic               last;
        int                 reps;
        bit                 typed;
        t_frame_result      want;
    } t_row;

    // bin rows: reps bins of one magnitude, frame end on the final one if last
    t_row dir_rows [N_ROWS] = '{
        '{ROW_BIN, CFG_BAND_LOW,  24'hFFFFFF, 1'b1, 1030, 1'b1,
          '{35'sd0, 35'sd0, 1'b0, 1'b0}},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000000, 1'b1, 12, 1'b1,
          '{-35'sd201326580, -35'sd201326580, 1'b0, 1'b0}},
        '{ROW_BIN, CFG_BAND_LOW,  24'hFFFFFF, 1'b1, 12, 1'b1,
          '{35'sd201326580, 35'sd201326580, 1'b1, 1'b1}},
        '{ROW_CFG, CFG_THRESHOLD, 24'h000000, 1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000000, 1'b1, 12, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000001, 1'b1, 12, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000002, 1'b1, 12, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_LOW,  24'd5,      1'b0, 1, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_HIGH, 24'd2,      1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'h800000, 1'b1, 4, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_LOW,  24'd1023,   1'b0, 1, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_HIGH, 24'd1023,   1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000001, 1'b1, 3, 1'b0, '0},
        '{ROW_CFG, CFG_THRESHOLD, 24'hFFFFFF, 1'b0, 1, 1'b0, '0},
        '{ROW_CFG, CFG_UNUSED,    24'hABCDEF, 1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'hFFFFFF, 1'b1, 1, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_LOW,  24'd0,      1'b0, 1, 1'b0, '0},
        '{ROW_CFG, CFG_BAND_HIGH, 24'd0,      1'b0, 1, 1'b0, '0},
        '{ROW_CFG, CFG_THRESHOLD, 24'd100,    1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'd0,      1'b1, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'd100,    1'b1, 1, 1'b1,
          '{35'sd100, 35'sd100, 1'b0, 1'b0}},
        '{ROW_BIN, CFG_BAND_LOW,  24'd0,      1'b1, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'd101,    1'b1, 1, 1'b1,
          '{35'sd101, 35'sd101, 1'b1, 1'b1}},
        '{ROW_BIN, CFG_BAND_LOW,  24'h000000, 1'b0, 1, 1'b0, '0},
        '{ROW_BIN, CFG_BAND_LOW,  24'hFFFFFF, 1'b1, 1, 1'b0, '0}
    };

    logic               i_clk      = 1'b0;
    logic               i_rst_n    = 1'b0;
    logic               cfg_we     = 1'b0;
    logic [CFG_A_W-1:0] cfg_idx    = '0;
    logic [CFG_D_W-1:0] cfg_data   = '0;
    logic               in_valid   = 1'b0;
    logic [MAG_W-1:0]   magnitude  = '0;
    logic               frame_end  = 1'b0;
    logic               out_ready  = 1'b0;
    logic               o_in_ready;
    logic               o_out_valid;
    t_flux              o_band_flux;
    t_flux              o_total_flux;
    logic               o_over_threshold;
    logic               o_beat;

    int send_idle_pct = 24;
    int recv_idle_pct = 60;
    int cycles        = 0;
    int errors        = 0;

    // predictor state
    logic [MAG_W-1:0]  prev_mag [MAX_BINS];
    bit                have_prev = 1'b0;
    bit                prev_over = 1'b0;
    int unsigned       bin_idx   = 0;
    longint            band_acc  = 0;
    longint            all_acc   = 0;
    logic [BAND_W-1:0] band_lo   = BAND_LOW_RST;
    logic [BAND_W-1:0] band_hi   = BAND_HIGH_RST;
    logic [THR_W-1:0]  thr       = THRESHOLD_RST;

    t_frame_result frame_results [$];
    t_frame_result want;

    spectral_flux_beat_detector u_dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (cfg_we),
        .i_cfg_idx        (cfg_idx),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (in_valid),
        .o_in_ready       (o_in_ready),
        .i_magnitude      (magnitude),
        .i_frame_end      (frame_end),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (out_ready),
        .o_band_flux      (o_band_flux),
        .o_total_flux     (o_total_flux),
        .o_over_threshold (o_over_threshold),
        .o_beat           (o_beat)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic flag_error(input string msg);
        errors++;
        if (errors <= MAX_REPORTS)
            $display("ERROR cycle %0d: %s", cycles, msg);
    endtask

    function automatic void clamp_flux(input longint v, output t_flux f);
        if (v > longint'(FLUX_MAX))
            f = FLUX_MAX;
        else if (v < longint'(FLUX_MIN))
            f = FLUX_MIN;
        else
            f = t_flux'(v);
    endfunction

    // one bin through the predictor; returns 1 when the bin closes a frame
    function automatic bit flux_step(input logic [MAG_W-1:0] mag, input logic last,
                                     output t_frame_result res);
        logic [BAND_W-1:0] lo;
        longint            diff;
        t_flux             bf;
        t_flux             tf;
        bit                over;
        if (bin_idx < MAX_BINS) begin
            lo = (band_lo > band_hi) ? band_hi : band_lo;
            diff = longint'(mag) - longint'(prev_mag[bin_idx[BIN_W-1:0]]);
            prev_mag[bin_idx[BIN_W-1:0]] = mag;
            all_acc += diff;
            if (bin_idx >= 32'(lo) && bin_idx <= 32'(band_hi))
                band_acc += diff;
            bin_idx++;
        end
        res = '0;
        if (!last)
            return 1'b0;
        bf = '0;
        tf = '0;
        over = 1'b0;
        // first frame after reset only fills the store
        if (have_prev) begin
            clamp_flux(band_acc, bf);
            clamp_flux(all_acc, tf);
            over = longint'(bf) > longint'(thr);
        end
        res.band_flux  = bf;
        res.total_flux = tf;
        res.over       = over;
        res.beat       = over && !prev_over;
        prev_over = over;
        have_prev = 1'b1;
        bin_idx   = 0;
        band_acc  = 0;
        all_acc   = 0;
        return 1'b1;
    endfunction

    task automatic stream_bin(input logic [MAG_W-1:0] mag, input logic last,
                              input bit typed, input t_frame_result typed_res);
        t_frame_result res;
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid  <= 1'b1;
        magnitude <= mag;
        frame_end <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        if (flux_step(mag, last, res))
            frame_results.push_back(typed ? typed_res : res);
    endtask

    // drop valid, let every pending beat out and the pipe run dry
    task automatic settle();
        in_valid <= 1'b0;
        while (frame_results.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_A_W-1:0] idx, input logic [CFG_D_W-1:0] data);
        settle();
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge i_clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_BAND_LOW:  band_lo = data[BAND_W-1:0];
            CFG_BAND_HIGH: band_hi = data[BAND_W-1:0];
            CFG_THRESHOLD: thr     = data[THR_W-1:0];
            default: ;
        endcase
    endtask

    task automatic random_frame(input int len);
        logic [MAG_W-1:0] m;
        for (int i = 0; i < len; i++) begin
            case ($urandom_range(7))
                0:       m = '0;
                1:       m = '1;
                2:       m = MAG_W'($urandom_range(0, 255));
                default: m = MAG_W'($urandom());
            endcase
            stream_bin(m, i == len - 1, 1'b0, '0);
        end
    endtask

    function automatic logic [BAND_W-1:0] pick_bin();
        case ($urandom_range(3))
            0:       return '0;
            1:       return '1;
            default: return BAND_W'($urandom_range(0, 30));
        endcase
    endfunction

    // output side: random stalls, compare each beat with the oldest expectation
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && out_ready) begin
            if (frame_results.size() == 0) begin
                flag_error("beat with no frame result pending");
            end else begin
                want = frame_results.pop_front();
                if (o_band_flux !== want.band_flux)
                    flag_error($sformatf("band_flux got %0d want %0d",
                                         o_band_flux, want.band_flux));
                if (o_total_flux !== want.total_flux)
                    flag_error($sformatf("total_flux got %0d want %0d",
                                         o_total_flux, want.total_flux));
                if (o_over_threshold !== want.over)
                    flag_error($sformatf("over_threshold got %b want %b",
                                         o_over_threshold, want.over));
                if (o_beat !== want.beat)
                    flag_error($sformatf("beat got %b want %b", o_beat, want.beat));
            end
        end
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial begin : stim
        int               sent;
        int               len;
        logic [CFG_D_W-1:0] thr_val;
        for (int i = 0; i < MAX_BINS; i++)
            prev_mag[BIN_W'(i)] = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: the first frame overruns the store so every entry is written
        foreach (dir_rows[r]) begin
            if (dir_rows[r].kind == ROW_CFG) begin
                write_reg(dir_rows[r].idx, dir_rows[r].val);
            end else begin
                for (int k = 0; k < dir_rows[r].reps; k++)
                    stream_bin(dir_rows[r].val[MAG_W-1:0],
                               dir_rows[r].last && (k == dir_rows[r].reps - 1),
                               dir_rows[r].typed, dir_rows[r].want);
            end
        end

        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin
                    send_idle_pct = 24;
                    recv_idle_pct = 60;
                end
                1: begin
                    send_idle_pct = 60;
                    recv_idle_pct = 24;
                end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int blk = 0; blk < 4; blk++) begin
                // upper data bits are don't-care for the band registers
                write_reg(CFG_BAND_LOW,
                          CFG_D_W'(($urandom() & 24'hFFFC00) | pick_bin()));
                write_reg(CFG_BAND_HIGH,
                          CFG_D_W'(($urandom() & 24'hFFFC00) | pick_bin()));
                case ($urandom_range(3))
                    0:       thr_val = '0;
                    1:       thr_val = '1;
                    2:       thr_val = CFG_D_W'($urandom());
                    default: thr_val = CFG_D_W'($urandom_range(0, 24'h3FFFFF));
                endcase
                write_reg(CFG_THRESHOLD, thr_val);
                sent = 0;
                while (sent < 50) begin
                    if ($urandom_range(15) == 0)
                        len = $urandom_range(100, 300);
                    else
                        len = $urandom_range(1, 24);
                    random_frame(len);
                    sent += len;
                end
            end
        end

        settle();
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
`default_nettype wire

// File: spectral_flux_beat_detector.f
hdl/sfbd_pkg.sv
hdl/spectral_flux_beat_detector.sv
tb/sv/tb_top.sv
